@@ sv/sxkr_pkg.sv @@
// ---------------------------------------------------------------------------
// sxkr_pkg
// shared types and constants of the single-byte xor key recovery unit
// ---------------------------------------------------------------------------
package sxkr_pkg;

	localparam int BYTE_W   = 8;
	localparam int HIST_W   = 7;
	localparam int NUM_BINS = 256;

	localparam logic [BYTE_W-1:0] COMMON_BYTE_RST = 8'h20;
	localparam logic [BYTE_W-1:0] LAST_BIN        = 8'hFF;

	// control from the sequencer to the histogram
	typedef struct packed {
		logic              inc;
		logic [BYTE_W-1:0] inc_bin;
		logic              sweep;
		logic [BYTE_W-1:0] sweep_bin;
		logic              track;
		logic              first;
	} hist_ctl_t;

endpackage

@@ sv/sxkr_if.sv @@
// ---------------------------------------------------------------------------
// sxkr_in_if / sxkr_out_if
// valid/ready channels for ciphertext beats and decoded beats
// ---------------------------------------------------------------------------
interface sxkr_in_if;
	import sxkr_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] cipher_byte;
	logic              last_in;

	modport source (output valid, output cipher_byte, output last_in, input ready);
	modport sink   (input valid, input cipher_byte, input last_in, output ready);
endinterface

interface sxkr_out_if;
	import sxkr_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] plain_byte;
	logic [BYTE_W-1:0] recovered_key;
	logic              last_out;
	logic              overflowed;

	modport source (output valid, output plain_byte, output recovered_key,
		output last_out, output overflowed, input ready);
	modport sink   (input valid, input plain_byte, input recovered_key,
		input last_out, input overflowed, output ready);
endinterface

@@ sv/sxkr_store.sv @@
// ---------------------------------------------------------------------------
// sxkr_store
// message buffer, one write port and one registered read port
// ---------------------------------------------------------------------------
module sxkr_store #(
	parameter int MAX_LEN = 64
) (
	input  logic                               clk,
	input  logic                               we,
	input  logic [$clog2(MAX_LEN)-1:0]         waddr,
	input  logic [sxkr_pkg::BYTE_W-1:0]        wdata,
	input  logic [$clog2(MAX_LEN)-1:0]         raddr,
	output logic [sxkr_pkg::BYTE_W-1:0]        rdata
);
	import sxkr_pkg::*;

	logic [BYTE_W-1:0] mem [MAX_LEN];
	logic [BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/sxkr_hist.sv @@
// ---------------------------------------------------------------------------
// sxkr_hist
// 256-bin histogram memory: counting with read-modify-write and forwarding,
// sweep that zeroes bins and, when tracking is asked for, finds the most frequent one
// ---------------------------------------------------------------------------
module sxkr_hist (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sxkr_pkg::hist_ctl_t           ctl,
	output logic [sxkr_pkg::BYTE_W-1:0]   best_bin
);
	import sxkr_pkg::*;

	logic [HIST_W-1:0] mem [NUM_BINS];
	logic [HIST_W-1:0] rdata_q;

	logic              inc_s1;
	logic [BYTE_W-1:0] bin_s1;
	logic              track_s1;
	logic              first_s1;

	logic              wr_v_q;
	logic [BYTE_W-1:0] wr_bin_q;
	logic [HIST_W-1:0] wr_cnt_q;

	logic [HIST_W-1:0] best_cnt_q;
	logic [BYTE_W-1:0] best_bin_q;

	logic [BYTE_W-1:0] raddr;
	logic [HIST_W-1:0] cnt_cur;
	logic [HIST_W-1:0] cnt_nxt;

	assign raddr   = ctl.sweep ? ctl.sweep_bin : ctl.inc_bin;
	// previous increment of the same bin has not been seen by this read
	assign cnt_cur = (wr_v_q && wr_bin_q == bin_s1) ? wr_cnt_q : rdata_q;
	assign cnt_nxt = cnt_cur + HIST_W'(1);

	always_ff @(posedge clk) begin
		if (inc_s1) begin
			mem[bin_s1] <= cnt_nxt;
		end else if (ctl.sweep) begin
			mem[ctl.sweep_bin] <= '0;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_s1     <= 1'b0;
			bin_s1     <= '0;
			track_s1   <= 1'b0;
			first_s1   <= 1'b0;
			wr_v_q     <= 1'b0;
			wr_bin_q   <= '0;
			wr_cnt_q   <= '0;
			best_cnt_q <= '0;
			best_bin_q <= '0;
		end else begin
			inc_s1   <= ctl.inc;
			bin_s1   <= ctl.sweep ? ctl.sweep_bin : ctl.inc_bin;
			track_s1 <= ctl.track;
			first_s1 <= ctl.first;
			wr_v_q   <= inc_s1;
			wr_bin_q <= bin_s1;
			wr_cnt_q <= cnt_nxt;
			// strict compare in ascending order keeps the lowest bin on ties
			if (track_s1) begin
				if (first_s1 || rdata_q > best_cnt_q) begin
					best_cnt_q <= rdata_q;
					best_bin_q <= bin_s1;
				end
			end
		end
	end

	assign best_bin = best_bin_q;

endmodule

@@ sv/single_byte_xor_key_recovery_unit.sv @@
// ciphertext beats are taken one per cycle, but only in the load state; after
// the last beat the histogram sweep reads and clears every bin, the key is
// formed and the decoded beats follow, each fetched from the message buffer
// (registered read) before it is sent and held while the receiver stalls; no
// new beat is taken until the last decoded beat is issued. after reset a sweep
// clears the histogram before the first beat is taken; the assumed common byte resets to a space
// ---------------------------------------------------------------------------
// single_byte_xor_key_recovery_unit
// buffers a message, finds its most frequent byte and decodes the message
// with that byte xor the assumed common plaintext byte
// ---------------------------------------------------------------------------
module single_byte_xor_key_recovery_unit #(
	parameter int MAX_LEN = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	sxkr_in_if.sink                     cipher,
	sxkr_out_if.source                  plain,
	input  logic                        cfg_we,
	input  logic [sxkr_pkg::BYTE_W-1:0] cfg_wdata
);
	import sxkr_pkg::*;

	localparam int IDX_W = $clog2(MAX_LEN);
	localparam int CNT_W = $clog2(MAX_LEN + 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_LOAD,
		ST_DRAIN,
		ST_SCAN,
		ST_FIN,
		ST_KEY,
		ST_EMIT
	} state_t;

	state_t            state_q;
	logic [BYTE_W-1:0] sweep_q;
	logic [CNT_W-1:0]  count_q;
	logic              ovf_q;
	logic [BYTE_W-1:0] common_q;
	logic [BYTE_W-1:0] key_q;
	logic [IDX_W-1:0]  emit_idx_q;
	logic              fetched_q;

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_plain_q;
	logic [BYTE_W-1:0] out_key_q;
	logic              out_last_q;
	logic              out_ovf_q;

	hist_ctl_t         hctl;
	logic [BYTE_W-1:0] best_bin;
	logic [BYTE_W-1:0] st_rdata;
	logic              acc;
	logic              full;
	logic              st_we;
	logic              out_free;
	logic              emit_last;

	assign cipher.ready = (state_q == ST_LOAD);
	assign acc          = cipher.valid && cipher.ready;
	assign full         = (count_q == CNT_W'(MAX_LEN));
	assign st_we        = acc && !full;
	assign out_free     = !out_valid_q || plain.ready;
	assign emit_last    = ((CNT_W'(emit_idx_q) + CNT_W'(1)) == count_q);

	always_comb begin
		hctl.inc       = st_we;
		hctl.inc_bin   = cipher.cipher_byte;
		hctl.sweep     = (state_q == ST_CLEAR) || (state_q == ST_SCAN);
		hctl.sweep_bin = sweep_q;
		hctl.track     = (state_q == ST_SCAN);
		hctl.first     = (sweep_q == '0);
	end

	sxkr_hist u_hist (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (hctl),
		.best_bin (best_bin)
	);

	sxkr_store #(
		.MAX_LEN (MAX_LEN)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (cipher.cipher_byte),
		.raddr (emit_idx_q),
		.rdata (st_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			sweep_q     <= '0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			common_q    <= COMMON_BYTE_RST;
			key_q       <= '0;
			emit_idx_q  <= '0;
			fetched_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_plain_q <= '0;
			out_key_q   <= '0;
			out_last_q  <= 1'b0;
			out_ovf_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				common_q <= cfg_wdata;
			end
			if (plain.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					sweep_q <= sweep_q + BYTE_W'(1);
					if (sweep_q == LAST_BIN) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (acc) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
						if (cipher.last_in) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					sweep_q <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					sweep_q <= sweep_q + BYTE_W'(1);
					if (sweep_q == LAST_BIN) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_KEY;
				end
				ST_KEY: begin
					key_q      <= best_bin ^ common_q;
					emit_idx_q <= '0;
					fetched_q  <= 1'b0;
					state_q    <= ST_EMIT;
				end
				ST_EMIT: begin
					if (fetched_q && out_free) begin
						out_valid_q <= 1'b1;
						out_plain_q <= st_rdata ^ key_q;
						out_key_q   <= key_q;
						out_last_q  <= emit_last;
						out_ovf_q   <= ovf_q;
						emit_idx_q  <= emit_idx_q + IDX_W'(1);
						fetched_q   <= 1'b0;
						if (emit_last) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end
					end else begin
						fetched_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	assign plain.valid         = out_valid_q;
	assign plain.plain_byte    = out_plain_q;
	assign plain.recovered_key = out_key_q;
	assign plain.last_out      = out_last_q;
	assign plain.overflowed    = out_ovf_q;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// checks the single-byte xor key recovery unit: ciphertext messages are
// driven beat by beat, a local predictor counts byte values, picks the most
// frequent byte (lowest value on a tie) and decodes the stored message, and
// every decoded beat is compared field by field in arrival order. runs cover
// short, full and overflowing messages, ties, several assumed common bytes,
// random idling on both channels and a long receiver hold-off
// ---------------------------------------------------------------------------
module tb_top;
	import sxkr_pkg::*;

	localparam int MSG_CAP       = 64;
	localparam int SETTLE_CYCLES = 320;
	localparam int HOLD_CYCLES   = 800;
	localparam int QUIET_LIMIT   = 4000;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} cipher_beat_t;

	typedef struct packed {
		logic [BYTE_W-1:0] plain;
		logic [BYTE_W-1:0] key;
		logic              last;
		logic              ovf;
	} decoded_beat_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic [BYTE_W-1:0] cfg_wdata = '0;

	sxkr_in_if  cipher_ch ();
	sxkr_out_if plain_ch ();

	single_byte_xor_key_recovery_unit #(
		.MAX_LEN (MSG_CAP)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cipher    (cipher_ch),
		.plain     (plain_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	cipher_beat_t  cipher_q [$];
	decoded_beat_t decoded_q [$];

	// predictor state
	logic [BYTE_W-1:0] common_byte = COMMON_BYTE_RST;
	logic [HIST_W-1:0] byte_count [NUM_BINS];
	logic [BYTE_W-1:0] msg_buf [MSG_CAP];
	int                msg_len = 0;
	logic              dropped = 1'b0;

	int   errors        = 0;
	bit   idle_en       = 1'b1;
	int   hold_requests = 0;
	int   holds_served  = 0;
	int   send_gap      = 0;
	int   recv_stall    = 0;
	int   quiet_cycles  = 0;

	initial begin
		foreach (byte_count[i])
			byte_count[i] = '0;
	end

	function automatic void recover_and_decode(input logic [BYTE_W-1:0] data, input logic last);
		int                best;
		logic [BYTE_W-1:0] key;
		decoded_beat_t     d;
		if (msg_len < MSG_CAP) begin
			msg_buf[msg_len] = data;
			msg_len++;
			byte_count[data] = byte_count[data] + 1'b1;
		end else begin
			dropped = 1'b1;
		end
		if (last) begin
			best = 0;
			for (int v = 1; v < NUM_BINS; v++)
				if (byte_count[v] > byte_count[best])
					best = v;
			key = BYTE_W'(best) ^ common_byte;
			for (int k = 0; k < msg_len; k++) begin
				d.plain = msg_buf[k] ^ key;
				d.key   = key;
				d.last  = (k == msg_len - 1);
				d.ovf   = dropped;
				decoded_q.push_back(d);
			end
			foreach (byte_count[i])
				byte_count[i] = '0;
			msg_len = 0;
			dropped = 1'b0;
		end
	endfunction

	function automatic void check_field(input string name, input logic [BYTE_W-1:0] exp_v,
		input logic [BYTE_W-1:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
			errors++;
		end
	endfunction

	function automatic void push_beat(input logic [BYTE_W-1:0] data, input logic last);
		cipher_beat_t b;
		b.data = data;
		b.last = last;
		cipher_q.push_back(b);
	endfunction

	// skewed messages have one hot byte, like plaintext with a common letter
	task automatic add_message(input int len, input bit skewed);
		logic [BYTE_W-1:0] hot;
		hot = BYTE_W'($urandom);
		for (int i = 0; i < len; i++)
			push_beat((skewed && $urandom_range(0, 1) == 1) ? hot : BYTE_W'($urandom),
				i == len - 1);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (cipher_q.size() != 0 || cipher_ch.valid || decoded_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_common_byte(input logic [BYTE_W-1:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we      <= 1'b0;
		common_byte = v;
	endtask

	// cipher driver
	always @(posedge clk) begin
		cipher_beat_t b;
		if (!arst_n) begin
			cipher_ch.valid       <= 1'b0;
			cipher_ch.cipher_byte <= '0;
			cipher_ch.last_in     <= 1'b0;
			send_gap              <= 0;
		end else if (cipher_ch.valid && !cipher_ch.ready) begin
		end else if (send_gap != 0) begin
			send_gap        <= send_gap - 1;
			cipher_ch.valid <= 1'b0;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			send_gap        <= $urandom_range(0, 7);
			cipher_ch.valid <= 1'b0;
		end else if (cipher_q.size() != 0) begin
			b = cipher_q.pop_front();
			cipher_ch.valid       <= 1'b1;
			cipher_ch.cipher_byte <= b.data;
			cipher_ch.last_in     <= b.last;
		end else begin
			cipher_ch.valid <= 1'b0;
		end
	end

	// receiver ready, with stall bursts and the long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			plain_ch.ready <= 1'b0;
			recv_stall     <= 0;
		end else if (holds_served != hold_requests) begin
			holds_served   <= holds_served + 1;
			recv_stall     <= HOLD_CYCLES - 1;
			plain_ch.ready <= 1'b0;
		end else if (recv_stall != 0) begin
			recv_stall     <= recv_stall - 1;
			plain_ch.ready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			recv_stall     <= $urandom_range(0, 7);
			plain_ch.ready <= 1'b0;
		end else begin
			plain_ch.ready <= 1'b1;
		end
	end

	// monitor: predict on cipher beats, check decoded beats
	always @(posedge clk) begin
		decoded_beat_t e;
		if (arst_n) begin
			if (cipher_ch.valid && cipher_ch.ready)
				recover_and_decode(cipher_ch.cipher_byte, cipher_ch.last_in);
			if (plain_ch.valid && plain_ch.ready) begin
				if (decoded_q.size() == 0) begin
					$error("unexpected decoded beat: plain_byte %0h", plain_ch.plain_byte);
					errors++;
				end else begin
					e = decoded_q.pop_front();
					check_field("plain_byte", e.plain, plain_ch.plain_byte);
					check_field("recovered_key", e.key, plain_ch.recovered_key);
					check_field("last_out", BYTE_W'(e.last), BYTE_W'(plain_ch.last_out));
					check_field("overflowed", BYTE_W'(e.ovf), BYTE_W'(plain_ch.overflowed));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((cipher_ch.valid && cipher_ch.ready) || (plain_ch.valid && plain_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		cipher_ch.valid       = 1'b0;
		cipher_ch.cipher_byte = '0;
		cipher_ch.last_in     = 1'b0;
		plain_ch.ready        = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset common byte
		push_beat(8'h00, 1'b1);
		push_beat(8'hFF, 1'b1);
		push_beat(8'hFF, 1'b0);
		push_beat(8'h80, 1'b0);
		push_beat(8'hFF, 1'b0);
		push_beat(8'h80, 1'b1);
		push_beat(8'h01, 1'b0);
		push_beat(8'hFE, 1'b0);
		push_beat(8'h7F, 1'b1);
		push_beat(8'h55, 1'b0);
		push_beat(8'hAA, 1'b0);
		push_beat(8'hAA, 1'b0);
		push_beat(8'h55, 1'b0);
		push_beat(8'h55, 1'b1);
		wait_drained();

		// extreme common byte low
		set_common_byte(8'h00);
		for (int m = 0; m < 3; m++)
			add_message($urandom_range(1, 6), $urandom_range(0, 3) != 0);
		wait_drained();

		// full and overflowing store, long receiver hold-off, sender still offering beats
		set_common_byte(8'hFF);
		hold_requests++;
		add_message(MSG_CAP + 1, 1'b1);
		add_message(3, 1'b0);
		wait_drained();

		set_common_byte(BYTE_W'($urandom));
		for (int m = 0; m < 2; m++)
			add_message($urandom_range(1, 6), $urandom_range(0, 3) != 0);
		wait_drained();

		// back to space, no idling
		set_common_byte(COMMON_BYTE_RST);
		idle_en = 1'b0;
		for (int m = 0; m < 2; m++)
			add_message($urandom_range(1, 5), 1'b1);
		wait_drained();

		if (decoded_q.size() != 0) begin
			$error("decoded beats never arrived: %0d", decoded_q.size());
			errors++;
		end
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
